/* hw/rtl/button_debouncer_reset_combo_macros.svh */
// Assertion macros for the button debouncer with reset combo.
// Used by the top level only; no other dependencies.
`ifndef BUTTON_DEBOUNCER_RESET_COMBO_MACROS_SVH
`define BUTTON_DEBOUNCER_RESET_COMBO_MACROS_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define BDRC_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("bdrc assertion failed");
// Condition a implies condition b in the following cycle.
`define BDRC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("bdrc assertion failed");
`else
`define BDRC_ASSERT_NOW(label, clk, rst_n, a, b)
`define BDRC_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* hw/rtl/bdrc_pkg.sv */
// Shared constants, register indexes and status types for the button debouncer.
// No dependencies; every other file except the assertion macros header imports it.
`default_nettype none
package bdrc_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int BTN_IDX_W    = $clog2(BUTTON_COUNT);
    localparam int COUNT_W      = 8;
    localparam int HOLD_W       = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [COUNT_W-1:0]      DEBOUNCE_SAMPLES_RESET = COUNT_W'(20);
    localparam logic [HOLD_W-1:0]       HOLD_THRESHOLD_RESET   = HOLD_W'(2500);
    localparam logic [BUTTON_COUNT-1:0] RESET_MASK_RESET       = BUTTON_COUNT'(5);
    localparam logic [BTN_IDX_W-1:0]    PRF_BUTTON_RESET       = BTN_IDX_W'(1);
    localparam logic                    COMBO_ENABLE_RESET     = 1'b1;

    localparam logic [HOLD_W-1:0] HOLD_TOP = {HOLD_W{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_SAMPLES = 3'd0,
        CFG_HOLD_THRESHOLD   = 3'd1,
        CFG_RESET_MASK       = 3'd2,
        CFG_PRF_BUTTON       = 3'd3,
        CFG_COMBO_ENABLE     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic level;
        logic press;
        logic release_ev;
        logic unstable;
    } lane_status_t;

    typedef struct packed {
        logic request;
        logic force_recovery;
        logic counting;
    } combo_status_t;

endpackage
`default_nettype wire

/* hw/rtl/bdrc_sample_if.sv */
// Sample channel: one beat carries the raw pressed levels of all buttons.
// Depends on bdrc_pkg.
`default_nettype none
interface bdrc_sample_if
    import bdrc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [BUTTON_COUNT-1:0] raw_pressed;

    modport source (output valid, output raw_pressed, input ready);
    modport sink (input valid, input raw_pressed, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bdrc_result_if.sv */
// Result channel: one beat per sample with events, levels and combo status.
// Depends on bdrc_pkg.
`default_nettype none
interface bdrc_result_if
    import bdrc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [BUTTON_COUNT-1:0] press_events;
    logic [BUTTON_COUNT-1:0] release_events;
    logic [BUTTON_COUNT-1:0] stable_levels;
    logic                    reset_request;
    logic                    force_recovery;
    logic                    idle;

    modport source (output valid, output press_events, output release_events,
                    output stable_levels, output reset_request, output force_recovery,
                    output idle, input ready);
    modport sink (input valid, input press_events, input release_events,
                  input stable_levels, input reset_request, input force_recovery,
                  input idle, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bdrc_lane.sv */
// One button's stability counter and debounced level.
// Depends on bdrc_pkg.
`default_nettype none
module bdrc_lane
    import bdrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               raw,
    input  wire logic [COUNT_W-1:0] debounce_samples,
    output lane_status_t            status
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               level_reg;
    logic               level_next;
    logic [COUNT_W-1:0] count_inc;
    logic               differs;
    logic               flip;

    always_comb
    begin
        differs   = (raw != level_reg);
        // The counter wraps at its width, so a zero threshold takes a full turn.
        count_inc = count_reg + COUNT_W'(1);
        flip      = differs && (count_inc == debounce_samples);
        if (!differs || flip)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc;
        end
        level_next = flip ? raw : level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        status.level      = level_next;
        status.press      = flip && raw;
        status.release_ev = flip && !raw;
        status.unstable   = differs;
    end

endmodule
`default_nettype wire

/* hw/rtl/bdrc_combo.sv */
// Reset-combo hold counter and the recovery flag selection.
// Depends on bdrc_pkg.
`default_nettype none
module bdrc_combo
    import bdrc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [BUTTON_COUNT-1:0] levels,
    input  wire logic [HOLD_W-1:0]       hold_threshold,
    input  wire logic [BUTTON_COUNT-1:0] reset_mask,
    input  wire logic [BTN_IDX_W-1:0]    prf_button,
    input  wire logic                    combo_enable,
    output combo_status_t                status
);

    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic              held;

    always_comb
    begin
        // An empty mask counts as held whenever detection is on.
        held = combo_enable && ((levels & reset_mask) == reset_mask);
        if (!held)
        begin
            hold_next = '0;
        end
        else if (hold_reg == HOLD_TOP)
        begin
            hold_next = hold_reg;
        end
        else
        begin
            hold_next = hold_reg + HOLD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else if (step)
        begin
            hold_reg <= hold_next;
        end
    end

    always_comb
    begin
        status.counting       = held;
        status.request        = held && (hold_next > hold_threshold);
        status.force_recovery = status.request && levels[prf_button];
    end

endmodule
`default_nettype wire

/* hw/rtl/button_debouncer_reset_combo.sv */
// Button debouncer with reset combo: the result beat appears in the cycle after
// its sample beat is accepted, and one sample is taken every cycle while the
// result channel is not stalled. The rate is set by the single per-sample update
// of the button counters and the hold counter, followed by one result register.
// Reset clears all counters, releases every button and loads the default
// register values; there is no clearing pass.
`default_nettype none
`include "button_debouncer_reset_combo_macros.svh"
module button_debouncer_reset_combo
    import bdrc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    bdrc_sample_if.sink                 sample,
    bdrc_result_if.source               result,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0]      debounce_samples_reg;
    logic [HOLD_W-1:0]       hold_threshold_reg;
    logic [BUTTON_COUNT-1:0] reset_mask_reg;
    logic [BTN_IDX_W-1:0]    prf_button_reg;
    logic                    combo_enable_reg;

    logic                    step;
    lane_status_t            lane_status [BUTTON_COUNT];
    combo_status_t           combo_status;
    logic [BUTTON_COUNT-1:0] levels_next;
    logic [BUTTON_COUNT-1:0] press_next;
    logic [BUTTON_COUNT-1:0] release_next;
    logic [BUTTON_COUNT-1:0] unstable;

    logic                    valid_reg;
    logic [BUTTON_COUNT-1:0] press_reg;
    logic [BUTTON_COUNT-1:0] release_reg;
    logic [BUTTON_COUNT-1:0] levels_reg;
    logic                    request_reg;
    logic                    force_reg;
    logic                    idle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_samples_reg <= DEBOUNCE_SAMPLES_RESET;
            hold_threshold_reg   <= HOLD_THRESHOLD_RESET;
            reset_mask_reg       <= RESET_MASK_RESET;
            prf_button_reg       <= PRF_BUTTON_RESET;
            combo_enable_reg     <= COMBO_ENABLE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_SAMPLES: debounce_samples_reg <= cfg_data[COUNT_W-1:0];
                CFG_HOLD_THRESHOLD:   hold_threshold_reg   <= cfg_data[HOLD_W-1:0];
                CFG_RESET_MASK:       reset_mask_reg       <= cfg_data[BUTTON_COUNT-1:0];
                CFG_PRF_BUTTON:       prf_button_reg       <= cfg_data[BTN_IDX_W-1:0];
                CFG_COMBO_ENABLE:     combo_enable_reg     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // A new sample is taken whenever the result register is free or being emptied.
    assign sample.ready = !valid_reg || result.ready;
    assign step         = sample.valid && sample.ready;

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_lane
        bdrc_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .step             (step),
            .raw              (sample.raw_pressed[i]),
            .debounce_samples (debounce_samples_reg),
            .status           (lane_status[i])
        );

        assign levels_next[i]  = lane_status[i].level;
        assign press_next[i]   = lane_status[i].press;
        assign release_next[i] = lane_status[i].release_ev;
        assign unstable[i]     = lane_status[i].unstable;
    end

    bdrc_combo u_combo (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .levels         (levels_next),
        .hold_threshold (hold_threshold_reg),
        .reset_mask     (reset_mask_reg),
        .prf_button     (prf_button_reg),
        .combo_enable   (combo_enable_reg),
        .status         (combo_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            press_reg   <= press_next;
            release_reg <= release_next;
            levels_reg  <= levels_next;
            request_reg <= combo_status.request;
            force_reg   <= combo_status.force_recovery;
            idle_reg    <= !(|unstable) && !combo_status.counting;
        end
    end

    assign result.valid          = valid_reg;
    assign result.press_events   = press_reg;
    assign result.release_events = release_reg;
    assign result.stable_levels  = levels_reg;
    assign result.reset_request  = request_reg;
    assign result.force_recovery = force_reg;
    assign result.idle           = idle_reg;

    `BDRC_ASSERT_NEXT(a_beat_follows_sample, clk, rst_n, step, valid_reg)
    `BDRC_ASSERT_NOW(a_events_disjoint, clk, rst_n, valid_reg, (press_reg & release_reg) == '0)
    `BDRC_ASSERT_NOW(a_press_matches_level, clk, rst_n, valid_reg,
        ((press_reg & ~levels_reg) | (release_reg & levels_reg)) == '0)
    `BDRC_ASSERT_NOW(a_request_not_idle, clk, rst_n, valid_reg && request_reg,
        !idle_reg)
    `BDRC_ASSERT_NOW(a_force_needs_request, clk, rst_n, valid_reg && force_reg,
        request_reg)

endmodule
`default_nettype wire
